### sv/esv_pkg.sv
// Shared types and constants for the ElGamal signature check.
// No dependencies; imported by the controller, datapath and top level.
package esv_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_KEY = 2'd2;

    typedef enum logic [1:0] {
        MS_RED,
        MS_SQR,
        MS_MUL,
        MS_PROD
    } t_mul_sel;

    typedef enum logic [1:0] {
        PH_KEY,
        PH_SIG,
        PH_GEN
    } t_phase;

    typedef struct packed {
        logic     load_in;
        logic     exp_init;
        logic     exp_shift;
        logic     mul_start;
        t_mul_sel sel;
        t_phase   phase;
        logic     store;
        logic     load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
        logic mul_busy;
        logic exp_bit;
        logic exp_last;
        logic p_small;
    } t_dp_sts;

endpackage

### sv/esv_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Standalone; instantiated by esv_datapath. Requires i_a < i_m.
module esv_mulmod #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_m,
    output logic [W-1:0] o_res,
    output logic         o_busy,
    output logic         o_done
);

    localparam int CW = $clog2(W);

    logic [W-1:0]  r_acc, r_a, r_b;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;

    logic [W:0]   dbl, dbl_red, sum, sum_red, m_ext;
    logic [W-1:0] n_acc;

    always_comb begin
        m_ext   = {1'b0, i_m};
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
        sum     = dbl_red + {1'b0, r_a};
        sum_red = (sum >= m_ext) ? sum - m_ext : sum;
        n_acc   = r_b[W-1] ? sum_red[W-1:0] : dbl_red[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_cnt  <= CW'(W - 1);
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_b   <= r_b << 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res  = r_acc;
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

### sv/esv_datapath.sv
// Datapath: config registers, operand latches, exponent shifter, results.
// Depends on esv_pkg and esv_mulmod.
module esv_datapath
    import esv_pkg::*;
#(
    parameter int MOD_WIDTH  = 32,
    parameter int HASH_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [MOD_WIDTH-1:0]  i_cfg_data,
    input  logic [MOD_WIDTH-1:0]  i_sig_r,
    input  logic [MOD_WIDTH-1:0]  i_sig_s,
    input  logic [HASH_WIDTH-1:0] i_msg_hash,
    output logic                  o_valid_res,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts
);

    localparam int EXP_W = (MOD_WIDTH > HASH_WIDTH) ? MOD_WIDTH : HASH_WIDTH;
    localparam int ECW   = $clog2(EXP_W);

    logic [MOD_WIDTH-1:0]  r_mod, r_gen, r_key;
    logic [MOD_WIDTH-1:0]  r_r, r_s;
    logic [HASH_WIDTH-1:0] r_h;
    logic [EXP_W-1:0]      r_exp;
    logic [ECW-1:0]        r_ecnt;
    logic [MOD_WIDTH-1:0]  r_pw, r_base, r_fa, r_fb, r_f;
    logic                  r_match, r_res;
    t_mul_sel              r_sel;

    logic [MOD_WIDTH-1:0] mul_a, mul_b, red_src, mul_res;
    logic                 mul_busy, mul_done;

    always_comb begin
        case (i_cmd.phase)
            PH_KEY:  red_src = r_key;
            PH_SIG:  red_src = r_r;
            PH_GEN:  red_src = r_gen;
            default: red_src = r_gen;
        endcase
        case (i_cmd.sel)
            MS_RED: begin
                mul_a = MOD_WIDTH'(1);
                mul_b = red_src;
            end
            MS_SQR: begin
                mul_a = r_pw;
                mul_b = r_pw;
            end
            MS_MUL: begin
                mul_a = r_base;
                mul_b = r_pw;
            end
            default: begin
                mul_a = r_fa;
                mul_b = r_fb;
            end
        endcase
    end

    esv_mulmod #(
        .W (MOD_WIDTH)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_m     (r_mod),
        .o_res   (mul_res),
        .o_busy  (mul_busy),
        .o_done  (mul_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_WIDTH'(2);
            r_gen <= '0;
            r_key <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODULUS:    r_mod <= i_cfg_data;
                CFG_GENERATOR:  r_gen <= i_cfg_data;
                CFG_PUBLIC_KEY: r_key <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_r     <= i_sig_r;
            r_s     <= i_sig_s;
            r_h     <= i_msg_hash;
            r_match <= 1'b0;
        end
        if (i_cmd.exp_init) begin
            r_pw <= MOD_WIDTH'(1);
            case (i_cmd.phase)
                PH_KEY: begin
                    r_exp  <= EXP_W'(r_r) << (EXP_W - MOD_WIDTH);
                    r_ecnt <= ECW'(MOD_WIDTH - 1);
                end
                PH_SIG: begin
                    r_exp  <= EXP_W'(r_s) << (EXP_W - MOD_WIDTH);
                    r_ecnt <= ECW'(MOD_WIDTH - 1);
                end
                default: begin
                    r_exp  <= EXP_W'(r_h) << (EXP_W - HASH_WIDTH);
                    r_ecnt <= ECW'(HASH_WIDTH - 1);
                end
            endcase
        end else if (i_cmd.exp_shift) begin
            r_exp  <= r_exp << 1;
            r_ecnt <= r_ecnt - 1'b1;
        end
        if (i_cmd.mul_start) begin
            r_sel <= i_cmd.sel;
        end
        if (mul_done) begin
            case (r_sel)
                MS_RED:  r_base  <= mul_res;
                MS_SQR:  r_pw    <= mul_res;
                MS_MUL:  r_pw    <= mul_res;
                default: r_match <= (mul_res == r_f);
            endcase
        end
        if (i_cmd.store) begin
            case (i_cmd.phase)
                PH_KEY:  r_fa <= r_pw;
                PH_SIG:  r_fb <= r_pw;
                default: r_f  <= r_pw;
            endcase
        end
        if (i_cmd.load_out) begin
            r_res <= r_match;
        end
    end

    assign o_valid_res    = r_res;
    assign o_sts.mul_done = mul_done;
    assign o_sts.mul_busy = mul_busy;
    assign o_sts.exp_bit  = r_exp[EXP_W-1];
    assign o_sts.exp_last = (r_ecnt == '0);
    assign o_sts.p_small  = (r_mod[MOD_WIDTH-1:1] == '0);

endmodule

### sv/esv_ctrl.sv
// Controller: sequences reduction, square-and-multiply and final product.
// Depends on esv_pkg; drives esv_datapath through t_dp_cmd.
module esv_ctrl
    import esv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_WRED,
        S_WSQ,
        S_WML,
        S_NEXT,
        S_ADV,
        S_PROD,
        S_WPR,
        S_FIN
    } t_state;

    t_state  r_state;
    t_dp_cmd r_cmd;
    logic    r_ov;
    logic    in_acc, out_acc;

    assign in_acc  = (r_state == S_IDLE) && i_in_valid;
    assign out_acc = r_ov && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_cmd.exp_init  <= 1'b0;
            r_cmd.exp_shift <= 1'b0;
            r_cmd.mul_start <= 1'b0;
            r_cmd.store     <= 1'b0;
            r_cmd.load_out  <= 1'b0;
            if (out_acc) begin
                r_ov <= 1'b0;
            end
            if (r_cmd.load_out) begin
                r_ov <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd.phase <= PH_KEY;
                        r_state     <= i_sts.p_small ? S_FIN : S_INIT;
                    end
                end
                S_INIT: begin
                    r_cmd.exp_init  <= 1'b1;
                    r_cmd.mul_start <= 1'b1;
                    r_cmd.sel       <= MS_RED;
                    r_state         <= S_WRED;
                end
                S_WRED: begin
                    if (i_sts.mul_done) begin
                        r_cmd.mul_start <= 1'b1;
                        r_cmd.sel       <= MS_SQR;
                        r_state         <= S_WSQ;
                    end
                end
                S_WSQ: begin
                    if (i_sts.mul_done) begin
                        if (i_sts.exp_bit) begin
                            r_cmd.mul_start <= 1'b1;
                            r_cmd.sel       <= MS_MUL;
                            r_state         <= S_WML;
                        end else begin
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_WML: begin
                    if (i_sts.mul_done) begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (i_sts.exp_last) begin
                        r_cmd.store <= 1'b1;
                        r_state     <= (r_cmd.phase == PH_GEN) ? S_PROD : S_ADV;
                    end else begin
                        r_cmd.exp_shift <= 1'b1;
                        r_cmd.mul_start <= 1'b1;
                        r_cmd.sel       <= MS_SQR;
                        r_state         <= S_WSQ;
                    end
                end
                S_ADV: begin
                    r_cmd.phase <= (r_cmd.phase == PH_KEY) ? PH_SIG : PH_GEN;
                    r_state     <= S_INIT;
                end
                S_PROD: begin
                    r_cmd.mul_start <= 1'b1;
                    r_cmd.sel       <= MS_PROD;
                    r_state         <= S_WPR;
                end
                S_WPR: begin
                    if (i_sts.mul_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_ov || out_acc) begin
                        r_cmd.load_out <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // operands are latched at the transfer edge itself
    always_comb begin
        o_cmd         = r_cmd;
        o_cmd.load_in = in_acc;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.mul_start |-> !i_sts.mul_busy)
        else $error("multiply started while unit busy");

    a_accept_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_INIT || r_state == S_FIN))
        else $error("bad state after input transfer");

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_ov && !out_acc) |=> r_state == S_FIN)
        else $error("result overwrote pending output");

    a_out_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.load_out |=> r_ov)
        else $error("output loaded without valid");
`endif

endmodule

### sv/elgamal_signature_verify_top.sv
// Channel  | Handshake                 | Payload
// input    | i_in_valid / o_in_stall   | i_sig_r, i_sig_s, i_msg_hash
// output   | o_out_valid / i_out_stall | o_valid_res
// config   | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
// One item at a time; the modular multiplies in the bit-serial multiplier
// set the rate, plus one control step per exponent bit.
// If the modulus is below 2, the item skips the exponentiations and
// gives an invalid result.
// Synchronous active-low reset; a held result does not block acceptance of the
// next item, whose result then waits until the held one is taken.
// Top level; depends on esv_pkg, esv_ctrl, esv_datapath, esv_mulmod.
module elgamal_signature_verify_top
    import esv_pkg::*;
#(
    parameter int MOD_WIDTH  = 32,
    parameter int HASH_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [MOD_WIDTH-1:0]  i_sig_r,
    input  logic [MOD_WIDTH-1:0]  i_sig_s,
    input  logic [HASH_WIDTH-1:0] i_msg_hash,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_valid_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [MOD_WIDTH-1:0]  i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    esv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    esv_datapath #(
        .MOD_WIDTH  (MOD_WIDTH),
        .HASH_WIDTH (HASH_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sig_r     (i_sig_r),
        .i_sig_s     (i_sig_s),
        .i_msg_hash  (i_msg_hash),
        .o_valid_res (o_valid_res),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
